/* hw/rtl/ejg_pkg.sv */
// ----------------------------------------------------------------------------
// ejg_pkg: shared types, codes and arithmetic helpers
// Item and result layouts, queue entry, operation codes and Q16.16 helpers
// used by the element Jacobian geometry block.
// ----------------------------------------------------------------------------
package ejg_pkg;

	localparam int MAX_NODES_AXIS_DEF = 4;
	localparam int MAX_QUAD_AXIS_DEF  = 4;

	localparam int SLOT_W      = 6;
	localparam int NODE_SLOTS  = 1 << SLOT_W;
	localparam int BASIS_DEPTH = NODE_SLOTS * NODE_SLOTS;
	localparam int BASIS_AW    = 2 * SLOT_W;
	localparam int COUNT_W     = SLOT_W + 1;

	localparam int QUEUE_DEPTH = 2;

	localparam int DIV_NUM_W  = 48;
	localparam int DIV_BITS   = 4;
	localparam int DIV_CYCLES = DIV_NUM_W / DIV_BITS;

	localparam logic [1:0] MODE_BASIS = 2'd0;
	localparam logic [1:0] MODE_NODE  = 2'd1;
	localparam logic [1:0] MODE_POINT = 2'd2;

	localparam logic [1:0] CFG_DIMENSIONS = 2'd0;
	localparam logic [1:0] CFG_NODES_AXIS = 2'd1;
	localparam logic [1:0] CFG_QUAD_AXIS  = 2'd2;

	localparam logic [2:0] KIND_POS  = 3'd0;
	localparam logic [2:0] KIND_JAC0 = 3'd1;
	localparam logic [2:0] KIND_JAC1 = 3'd2;
	localparam logic [2:0] KIND_JAC2 = 3'd3;
	localparam logic [2:0] KIND_INV0 = 3'd4;
	localparam logic [2:0] KIND_INV1 = 3'd5;
	localparam logic [2:0] KIND_INV2 = 3'd6;
	localparam logic [2:0] KIND_DET  = 3'd7;

	localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

	typedef enum logic [1:0] {
		OP_BASIS,
		OP_NODE,
		OP_POINT
	} op_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [5:0]         quad_index;
		logic [5:0]         node_index;
		logic signed [31:0] basis_weight;
		logic signed [31:0] grad_x_weight;
		logic signed [31:0] grad_y_weight;
		logic signed [31:0] grad_z_weight;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
	} in_t;

	typedef struct packed {
		logic [5:0]         point_index;
		logic [2:0]         kind;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic signed [31:0] value_c;
		logic               singular;
		logic               last;
	} out_t;

	typedef struct packed {
		op_t op;
		in_t item;
	} cmd_t;

	// Q16.16 product, rounded towards minus infinity, kept unsaturated.
	function automatic logic signed [47:0] qmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return p[63:16];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < SAT_LO) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Nodes or points in the element: per-axis count clamped, raised to the
	// dimension, capped at the slot count.
	function automatic logic [COUNT_W-1:0] axis_count(input logic [2:0] per_axis,
			input int limit, input logic dim3);
		logic [3:0] a;
		logic [9:0] n;
		a = (per_axis == 3'd0) ? 4'd1 : {1'b0, per_axis};
		if (int'(a) > limit) a = 4'(limit);
		n = 10'(a) * 10'(a);
		if (dim3) n = 10'(n * 10'(a));
		if (n > 10'(NODE_SLOTS)) n = 10'(NODE_SLOTS);
		return COUNT_W'(n);
	endfunction

endpackage

/* hw/rtl/ejg_div.sv */
// ----------------------------------------------------------------------------
// ejg_div: signed Q16.16 divider
// Computes (num * 1.0) / den truncated towards zero and saturated, four
// quotient bits per cycle on magnitudes.
// ----------------------------------------------------------------------------
module ejg_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quo
);

	localparam int CNT_W = $clog2(ejg_pkg::DIV_CYCLES);
	localparam int NW    = ejg_pkg::DIV_NUM_W;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      rem_q;
	logic [NW-1:0]    sh_q;
	logic [NW-1:0]    qt_q;
	logic [31:0]      dvs_q;
	logic             neg_q;

	logic [31:0]   num_mag;
	logic [31:0]   den_mag;
	logic [31:0]   rem_nx;
	logic [NW-1:0] sh_nx;
	logic [NW-1:0] qt_nx;

	assign num_mag = num[31] ? (~num + 32'd1) : num;
	assign den_mag = den[31] ? (~den + 32'd1) : den;

	always_comb begin
		logic [32:0] t;
		rem_nx = rem_q;
		sh_nx  = sh_q;
		qt_nx  = qt_q;
		for (int i = 0; i < ejg_pkg::DIV_BITS; i++) begin
			t     = {rem_nx, sh_nx[NW-1]};
			sh_nx = {sh_nx[NW-2:0], 1'b0};
			if (t >= {1'b0, dvs_q}) begin
				t     = t - {1'b0, dvs_q};
				qt_nx = {qt_nx[NW-2:0], 1'b1};
			end else begin
				qt_nx = {qt_nx[NW-2:0], 1'b0};
			end
			rem_nx = t[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ejg_pkg::DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= {num_mag, 16'h0000};
			qt_q  <= '0;
			dvs_q <= den_mag;
			neg_q <= num[31] ^ den[31];
		end else if (busy_q) begin
			rem_q <= rem_nx;
			sh_q  <= sh_nx;
			qt_q  <= qt_nx;
		end
	end

	always_comb begin
		if (neg_q) begin
			quo = (qt_q > NW'(33'h1_0000_0000 >> 1)) ? 32'sh8000_0000 : (~qt_q[31:0] + 32'd1);
		end else begin
			quo = (qt_q > NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : qt_q[31:0];
		end
	end

endmodule

/* hw/rtl/ejg_fifo.sv */
// ----------------------------------------------------------------------------
// ejg_fifo: command queue
// Short queue that decouples item acceptance from execution.
// ----------------------------------------------------------------------------
module ejg_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ejg_pkg::cmd_t  cmd_in,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output ejg_pkg::cmd_t  cmd_out
);

	localparam int DEPTH = ejg_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);

	ejg_pkg::cmd_t   mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full    = (count_q == (PW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign cmd_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= cmd_in;
	end

endmodule

/* hw/rtl/ejg_front.sv */
// ----------------------------------------------------------------------------
// ejg_front: item acceptance and classification
// Turns accepted items into queue commands and drops those with no effect.
// ----------------------------------------------------------------------------
module ejg_front #(
	parameter int MAX_QUAD_AXIS = ejg_pkg::MAX_QUAD_AXIS_DEF
) (
	input  logic          start,
	input  ejg_pkg::in_t  item,
	input  logic          queue_full,
	input  logic          dim3,
	input  logic [2:0]    quad_per_axis,
	output logic          busy,
	output logic          push,
	output ejg_pkg::cmd_t cmd
);

	logic [ejg_pkg::COUNT_W-1:0] point_count;
	logic                        keep;

	assign point_count = ejg_pkg::axis_count(quad_per_axis, MAX_QUAD_AXIS, dim3);
	assign busy        = queue_full;

	// Points outside the element and the unused mode are taken and dropped.
	always_comb begin
		keep     = 1'b0;
		cmd.item = item;
		cmd.op   = ejg_pkg::OP_BASIS;
		case (item.mode)
			ejg_pkg::MODE_BASIS: begin
				keep   = 1'b1;
				cmd.op = ejg_pkg::OP_BASIS;
			end
			ejg_pkg::MODE_NODE: begin
				keep   = 1'b1;
				cmd.op = ejg_pkg::OP_NODE;
			end
			ejg_pkg::MODE_POINT: begin
				keep   = ({1'b0, item.quad_index} < point_count);
				cmd.op = ejg_pkg::OP_POINT;
			end
			default: keep = 1'b0;
		endcase
	end

	assign push = start && !queue_full && keep;

endmodule

/* hw/rtl/ejg_back.sv */
// ----------------------------------------------------------------------------
// ejg_back: command execution
// Holds the weight and node stores, accumulates position and Jacobian over
// the nodes, forms cofactors, determinant and inverse, and issues results.
// ----------------------------------------------------------------------------
module ejg_back #(
	parameter int MAX_NODES_AXIS = ejg_pkg::MAX_NODES_AXIS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  ejg_pkg::cmd_t q_cmd,
	output logic          q_pop,
	input  logic          dim3,
	input  logic [2:0]    nodes_per_axis,
	output logic          strobe,
	output ejg_pkg::out_t result
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC,
		ST_SAT,
		ST_COF,
		ST_DET,
		ST_DETSAT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT
	} state_t;

	localparam int CW = ejg_pkg::COUNT_W;

	state_t          state_q;
	logic [CW-1:0]   rd_cnt_q;
	logic            v_s1;
	logic            v_s2;
	logic [4:0]      step_q;
	logic [3:0]      elem_q;
	logic [2:0]      kind_q;

	logic signed [31:0] basis_mem  [ejg_pkg::BASIS_DEPTH];
	logic signed [31:0] grad_x_mem [ejg_pkg::BASIS_DEPTH];
	logic signed [31:0] grad_y_mem [ejg_pkg::BASIS_DEPTH];
	logic signed [31:0] grad_z_mem [ejg_pkg::BASIS_DEPTH];
	logic signed [31:0] node_x_mem [ejg_pkg::NODE_SLOTS];
	logic signed [31:0] node_y_mem [ejg_pkg::NODE_SLOTS];
	logic signed [31:0] node_z_mem [ejg_pkg::NODE_SLOTS];

	logic [5:0]         cur_q_q;
	logic signed [31:0] b_s1;
	logic signed [31:0] g_s1 [3];
	logic signed [31:0] x_s1 [3];
	logic signed [47:0] pb_s2 [3];
	logic signed [47:0] pg_s2 [9];
	logic signed [55:0] pos_acc_q [3];
	logic signed [55:0] jac_acc_q [9];
	logic signed [31:0] x_q [3];
	logic signed [31:0] a_q [9];
	logic signed [31:0] c_q [9];
	logic signed [31:0] inv_q [9];
	logic signed [47:0] prod_q;
	logic signed [63:0] det_acc_q;
	logic signed [31:0] det_q;

	logic [CW-1:0]               node_count;
	logic                        issue;
	logic [ejg_pkg::BASIS_AW-1:0] rd_addr;
	logic signed [31:0]          mul_a;
	logic signed [31:0]          mul_b;
	logic signed [47:0]          mul_p;
	logic                        det_sub;
	logic                        cof_last;
	logic                        det_last;
	logic                        div_start;
	logic                        div_done;
	logic signed [31:0]          div_quo;
	logic signed [31:0]          div_num;
	logic [3:0]                  tr_idx;

	assign node_count = ejg_pkg::axis_count(nodes_per_axis, MAX_NODES_AXIS, dim3);
	assign issue      = (rd_cnt_q < node_count);
	assign rd_addr    = {cur_q_q, rd_cnt_q[ejg_pkg::SLOT_W-1:0]};
	assign q_pop      = (state_q == ST_IDLE) && !q_empty;
	assign cof_last   = !dim3 || (step_q == 5'd17);
	assign det_last   = dim3 ? (step_q == 5'd2) : (step_q == 5'd1);
	assign div_start  = (state_q == ST_DIV_GO) && (det_q != '0);
	assign mul_p      = ejg_pkg::qmul(mul_a, mul_b);

	// Inverse entry (i, j) divides cofactor (j, i).
	always_comb begin
		case (elem_q)
			4'd0:    tr_idx = 4'd0;
			4'd1:    tr_idx = 4'd3;
			4'd2:    tr_idx = 4'd6;
			4'd3:    tr_idx = 4'd1;
			4'd4:    tr_idx = 4'd4;
			4'd5:    tr_idx = 4'd7;
			4'd6:    tr_idx = 4'd2;
			4'd7:    tr_idx = 4'd5;
			default: tr_idx = 4'd8;
		endcase
	end
	assign div_num = c_q[tr_idx];

	ejg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (det_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Operands of the shared multiplier. Each 3D cofactor takes two steps: the
	// even step forms the first product, the odd step the one subtracted.
	always_comb begin
		logic ph;
		ph      = step_q[0];
		mul_a   = '0;
		mul_b   = '0;
		det_sub = 1'b0;
		case (state_q)
			ST_COF: begin
				case (step_q[4:1])
					4'd0: begin mul_a = ph ? a_q[5] : a_q[4]; mul_b = ph ? a_q[7] : a_q[8]; end
					4'd1: begin mul_a = ph ? a_q[3] : a_q[5]; mul_b = ph ? a_q[8] : a_q[6]; end
					4'd2: begin mul_a = ph ? a_q[4] : a_q[3]; mul_b = ph ? a_q[6] : a_q[7]; end
					4'd3: begin mul_a = ph ? a_q[8] : a_q[7]; mul_b = ph ? a_q[1] : a_q[2]; end
					4'd4: begin mul_a = ph ? a_q[6] : a_q[8]; mul_b = ph ? a_q[2] : a_q[0]; end
					4'd5: begin mul_a = ph ? a_q[7] : a_q[6]; mul_b = ph ? a_q[0] : a_q[1]; end
					4'd6: begin mul_a = ph ? a_q[2] : a_q[1]; mul_b = ph ? a_q[4] : a_q[5]; end
					4'd7: begin mul_a = ph ? a_q[0] : a_q[2]; mul_b = ph ? a_q[5] : a_q[3]; end
					default: begin mul_a = ph ? a_q[1] : a_q[0]; mul_b = ph ? a_q[3] : a_q[4]; end
				endcase
			end
			ST_DET: begin
				if (dim3) begin
					case (step_q[1:0])
						2'd0:    begin mul_a = a_q[0]; mul_b = c_q[0]; end
						2'd1:    begin mul_a = a_q[1]; mul_b = c_q[1]; end
						default: begin mul_a = a_q[2]; mul_b = c_q[2]; end
					endcase
				end else if (step_q[0]) begin
					mul_a   = a_q[1];
					mul_b   = a_q[3];
					det_sub = 1'b1;
				end else begin
					mul_a = a_q[0];
					mul_b = a_q[4];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_cnt_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			step_q   <= '0;
			elem_q   <= '0;
			kind_q   <= ejg_pkg::KIND_POS;
			strobe   <= 1'b0;
		end else begin
			strobe <= (state_q == ST_EMIT);
			v_s1   <= (state_q == ST_ACC) && issue;
			v_s2   <= v_s1;
			case (state_q)
				ST_IDLE: begin
					if (q_pop && (q_cmd.op == ejg_pkg::OP_POINT)) begin
						state_q  <= ST_ACC;
						rd_cnt_q <= '0;
						kind_q   <= ejg_pkg::KIND_POS;
					end
				end
				ST_ACC: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end else if (!v_s1 && !v_s2) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					state_q <= ST_COF;
					step_q  <= '0;
				end
				ST_COF: begin
					if (cof_last) begin
						state_q <= ST_DET;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DET: begin
					if (det_last) begin
						state_q <= ST_DETSAT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DETSAT: begin
					state_q <= ST_DIV_GO;
					elem_q  <= '0;
				end
				ST_DIV_GO: begin
					state_q <= (det_q == '0) ? ST_EMIT : ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						if (elem_q == 4'd8) begin
							state_q <= ST_EMIT;
						end else begin
							elem_q  <= elem_q + 1'b1;
							state_q <= ST_DIV_GO;
						end
					end
				end
				ST_EMIT: begin
					if (kind_q == ejg_pkg::KIND_DET) begin
						state_q <= ST_IDLE;
					end else if (!dim3 && (kind_q == ejg_pkg::KIND_JAC1)) begin
						kind_q <= ejg_pkg::KIND_INV0;
					end else if (!dim3 && (kind_q == ejg_pkg::KIND_INV1)) begin
						kind_q <= ejg_pkg::KIND_DET;
					end else begin
						kind_q <= kind_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Stores: one write port for loads, one registered read for the node sweep.
	always_ff @(posedge clk) begin
		if (q_pop && (q_cmd.op == ejg_pkg::OP_BASIS)) begin
			basis_mem[{q_cmd.item.quad_index, q_cmd.item.node_index}]  <= q_cmd.item.basis_weight;
			grad_x_mem[{q_cmd.item.quad_index, q_cmd.item.node_index}] <= q_cmd.item.grad_x_weight;
			grad_y_mem[{q_cmd.item.quad_index, q_cmd.item.node_index}] <= q_cmd.item.grad_y_weight;
			grad_z_mem[{q_cmd.item.quad_index, q_cmd.item.node_index}] <= q_cmd.item.grad_z_weight;
		end
		if (q_pop && (q_cmd.op == ejg_pkg::OP_NODE)) begin
			node_x_mem[q_cmd.item.node_index] <= q_cmd.item.coord_x;
			node_y_mem[q_cmd.item.node_index] <= q_cmd.item.coord_y;
			node_z_mem[q_cmd.item.node_index] <= q_cmd.item.coord_z;
		end
		b_s1    <= basis_mem[rd_addr];
		g_s1[0] <= grad_x_mem[rd_addr];
		g_s1[1] <= grad_y_mem[rd_addr];
		g_s1[2] <= grad_z_mem[rd_addr];
		x_s1[0] <= node_x_mem[rd_cnt_q[ejg_pkg::SLOT_W-1:0]];
		x_s1[1] <= node_y_mem[rd_cnt_q[ejg_pkg::SLOT_W-1:0]];
		x_s1[2] <= node_z_mem[rd_cnt_q[ejg_pkg::SLOT_W-1:0]];
	end

	// Products of one node; the third axis is masked off in 2D.
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			pb_s2[c] <= ejg_pkg::qmul(b_s1, (c == 2 && !dim3) ? 32'sd0 : x_s1[c]);
			for (int k = 0; k < 3; k++) begin
				pg_s2[k*3+c] <= ejg_pkg::qmul((k == 2 && !dim3) ? 32'sd0 : g_s1[k],
						(c == 2 && !dim3) ? 32'sd0 : x_s1[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cur_q_q <= q_cmd.item.quad_index;
				for (int i = 0; i < 3; i++) pos_acc_q[i] <= '0;
				for (int i = 0; i < 9; i++) jac_acc_q[i] <= '0;
			end
			ST_ACC: begin
				if (v_s2) begin
					for (int i = 0; i < 3; i++) pos_acc_q[i] <= pos_acc_q[i] + 56'(pb_s2[i]);
					for (int i = 0; i < 9; i++) jac_acc_q[i] <= jac_acc_q[i] + 56'(pg_s2[i]);
				end
			end
			ST_SAT: begin
				for (int i = 0; i < 3; i++) x_q[i] <= ejg_pkg::sat32(64'(pos_acc_q[i]));
				for (int i = 0; i < 9; i++) a_q[i] <= ejg_pkg::sat32(64'(jac_acc_q[i]));
			end
			ST_COF: begin
				if (!dim3) begin
					c_q[0] <= a_q[4];
					c_q[1] <= ejg_pkg::sat32(-64'(a_q[3]));
					c_q[2] <= '0;
					c_q[3] <= ejg_pkg::sat32(-64'(a_q[1]));
					c_q[4] <= a_q[0];
					c_q[5] <= '0;
					c_q[6] <= '0;
					c_q[7] <= '0;
					c_q[8] <= '0;
				end else if (!step_q[0]) begin
					prod_q <= mul_p;
				end else begin
					c_q[step_q[4:1]] <= ejg_pkg::sat32(64'(prod_q) - 64'(mul_p));
				end
			end
			ST_DET: begin
				if (step_q == '0) begin
					det_acc_q <= 64'(mul_p);
				end else if (det_sub) begin
					det_acc_q <= det_acc_q - 64'(mul_p);
				end else begin
					det_acc_q <= det_acc_q + 64'(mul_p);
				end
			end
			ST_DETSAT: det_q <= ejg_pkg::sat32(det_acc_q);
			ST_DIV_GO: begin
				if (det_q == '0) begin
					for (int i = 0; i < 9; i++) inv_q[i] <= '0;
				end
			end
			ST_DIV_WAIT: begin
				if (div_done) inv_q[elem_q] <= div_quo;
			end
			ST_EMIT: begin
				result.point_index <= cur_q_q;
				result.kind        <= kind_q;
				result.singular    <= (det_q == '0);
				result.last        <= (kind_q == ejg_pkg::KIND_DET);
				case (kind_q)
					ejg_pkg::KIND_POS: begin
						result.value_a <= x_q[0]; result.value_b <= x_q[1]; result.value_c <= x_q[2];
					end
					ejg_pkg::KIND_JAC0: begin
						result.value_a <= a_q[0]; result.value_b <= a_q[1]; result.value_c <= a_q[2];
					end
					ejg_pkg::KIND_JAC1: begin
						result.value_a <= a_q[3]; result.value_b <= a_q[4]; result.value_c <= a_q[5];
					end
					ejg_pkg::KIND_JAC2: begin
						result.value_a <= a_q[6]; result.value_b <= a_q[7]; result.value_c <= a_q[8];
					end
					ejg_pkg::KIND_INV0: begin
						result.value_a <= inv_q[0]; result.value_b <= inv_q[1];
						result.value_c <= inv_q[2];
					end
					ejg_pkg::KIND_INV1: begin
						result.value_a <= inv_q[3]; result.value_b <= inv_q[4];
						result.value_c <= inv_q[5];
					end
					ejg_pkg::KIND_INV2: begin
						result.value_a <= inv_q[6]; result.value_b <= inv_q[7];
						result.value_c <= inv_q[8];
					end
					default: begin
						result.value_a <= det_q; result.value_b <= '0; result.value_c <= '0;
					end
				endcase
			end
			default: ;
		endcase
	end

endmodule

/* hw/rtl/element_jacobian_geometry.sv */
// ----------------------------------------------------------------------------
// element_jacobian_geometry: geometric factors of one element at a point
// Position, Jacobian, inverse Jacobian and determinant in Q16.16 from loaded
// shape weights and node coordinates, in 2D or 3D.
// ----------------------------------------------------------------------------
// An item is transferred when start is high and busy is low; a two-entry
// queue sits behind the port, so busy rises only when it is full. Load items
// (basis weights, node coordinates) only write the stores in the back end. A
// point item sweeps its N element nodes (one store read per node), forms the
// cofactors and then the determinant, then runs 9 divisions in the shared
// four-bit-per-cycle divider (skipped when the point is singular), and
// finally issues one result per cycle: 6 results in 2D, 8 in 3D. Results
// of one point come out on consecutive cycles, each held for exactly one
// cycle and marked by strobe; the receiver cannot stall them, so it must
// take every transfer as it comes. The final result of a point carries
// last. Configuration writes are always taken (cfg_ready is high) and must
// only be made while no point is in flight. Stores are not cleared by reset.
// ----------------------------------------------------------------------------
module element_jacobian_geometry #(
	parameter int MAX_NODES_AXIS = ejg_pkg::MAX_NODES_AXIS_DEF,
	parameter int MAX_QUAD_AXIS  = ejg_pkg::MAX_QUAD_AXIS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ejg_pkg::in_t  item,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [2:0]    cfg_data,
	output logic          strobe,
	output ejg_pkg::out_t result
);

	// Configuration registers.
	logic [1:0] dimensions_q;
	logic [2:0] nodes_axis_q;
	logic [2:0] quad_axis_q;
	logic       dim3;

	logic          push;
	logic          queue_full;
	logic          queue_empty;
	logic          pop;
	ejg_pkg::cmd_t push_cmd;
	ejg_pkg::cmd_t head_cmd;

	assign cfg_ready = 1'b1;
	assign dim3      = (dimensions_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dimensions_q <= 2'd2;
			nodes_axis_q <= 3'd2;
			quad_axis_q  <= 3'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ejg_pkg::CFG_DIMENSIONS: dimensions_q <= cfg_data[1:0];
				ejg_pkg::CFG_NODES_AXIS: nodes_axis_q <= cfg_data;
				ejg_pkg::CFG_QUAD_AXIS:  quad_axis_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front end classifies each transfer; only loads and points that lie
	// inside the element go into the queue.
	ejg_front #(
		.MAX_QUAD_AXIS (MAX_QUAD_AXIS)
	) u_front (
		.start         (start),
		.item          (item),
		.queue_full    (queue_full),
		.dim3          (dim3),
		.quad_per_axis (quad_axis_q),
		.busy          (busy),
		.push          (push),
		.cmd           (push_cmd)
	);

	ejg_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (push_cmd),
		.full    (queue_full),
		.pop     (pop),
		.empty   (queue_empty),
		.cmd_out (head_cmd)
	);

	// The back end executes commands strictly in order, so a load queued
	// behind a point never overtakes it.
	ejg_back #(
		.MAX_NODES_AXIS (MAX_NODES_AXIS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (queue_empty),
		.q_cmd          (head_cmd),
		.q_pop          (pop),
		.dim3           (dim3),
		.nodes_per_axis (nodes_axis_q),
		.strobe         (strobe),
		.result         (result)
	);

endmodule

/* hw/rtl/ejg_checker.sv */
// ----------------------------------------------------------------------------
// ejg_checker: port-level checks
// Checks result sequencing and the shape of determinant and singular results.
// ----------------------------------------------------------------------------
module ejg_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          strobe,
	input ejg_pkg::out_t result
);

	// The last flag marks the determinant and nothing else.
	a_last_is_det: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.last == (result.kind == ejg_pkg::KIND_DET)))
		else $error("last flag does not match determinant result");

	a_det_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.kind == ejg_pkg::KIND_DET) |->
		(result.value_b == '0 && result.value_c == '0))
		else $error("determinant result carries non-zero components");

	// A point's results come out back to back for the same point.
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) |=>
		(strobe && result.point_index == $past(result.point_index)))
		else $error("result burst broken");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.singular && (result.kind == ejg_pkg::KIND_INV0 ||
		result.kind == ejg_pkg::KIND_INV1 || result.kind == ejg_pkg::KIND_INV2)) |->
		(result.value_a == '0 && result.value_b == '0 && result.value_c == '0))
		else $error("singular inverse is not zero");

endmodule

bind element_jacobian_geometry ejg_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.strobe (strobe),
	.result (result)
);
